// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// ===== rtl/eoq_pkg.sv =====
// Types and constants of the elevator order queue.
`default_nettype none

package eoq_pkg;

   localparam int MASK_W   = 4;
   localparam int FLOORS   = MASK_W;
   localparam int FLOOR_W  = $clog2(FLOORS);
   localparam int HALL_W   = 4;
   localparam int CAB_W    = 3;
   localparam int CREDIT_W = 4;
   localparam int OP_W     = 3;
   localparam int DIR_W    = 2;

   localparam logic [CREDIT_W-1:0] CREDIT_RESET = 4'd3;

   typedef enum logic [OP_W-1:0] {
      OP_SCAN  = 3'd0,
      OP_CLEAR = 3'd1,
      OP_NEXT  = 3'd2,
      OP_DIR   = 3'd3,
      OP_STOP  = 3'd4
   } op_type;

   typedef enum logic [DIR_W-1:0] {
      DIR_STOP = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } dir_type;

   typedef enum logic [1:0] {
      PH_UP   = 2'd0,
      PH_DOWN = 2'd1,
      PH_CAB  = 2'd2
   } phase_type;

   typedef struct packed {
      logic               load;
      logic               scan_step;
      logic               clear_step;
      phase_type          phase;
      logic               next_step;
      logic               exec;
      logic               last;
      logic [FLOOR_W-1:0] idx;
      op_type             op;
      logic               done;
   } ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/eoq_ctrl.sv =====
// Sequencer: walks the floors once for scan and next, three times for clear; other ops execute directly.
`default_nettype none

module eoq_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [eoq_pkg::OP_W-1:0]  req_op,
   input  logic                      out_free,
   output logic                      req_ready,
   output eoq_pkg::ctrl_type         ctrl
);
   import eoq_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCAN  = 6'b000010,
      ST_CLEAR = 6'b000100,
      ST_NEXT  = 6'b001000,
      ST_EXEC  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [FLOOR_W-1:0] idx_ff, idx_in;
   phase_type          phase_ff, phase_in;
   op_type             op_ff, op_in;
   logic               last;

   assign last = (idx_ff == FLOOR_W'(FLOORS - 1));

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      phase_in = phase_ff;
      op_in    = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = op_type'(req_op);
               idx_in   = '0;
               phase_in = PH_UP;
               case (req_op)
                  OP_SCAN:  state_in = ST_SCAN;
                  OP_CLEAR: state_in = ST_CLEAR;
                  OP_NEXT:  state_in = ST_NEXT;
                  default:  state_in = ST_EXEC;
               endcase
            end
         end
         ST_SCAN, ST_NEXT: begin
            idx_in = last ? '0 : idx_ff + 1'b1;
            if (last) state_in = ST_DONE;
         end
         ST_CLEAR: begin
            idx_in = last ? '0 : idx_ff + 1'b1;
            if (last) begin
               if (phase_ff == PH_CAB) state_in = ST_DONE;
               else phase_in = phase_type'(phase_ff + 2'd1);
            end
         end
         ST_EXEC: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         phase_ff <= PH_UP;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign ctrl.load       = (state_ff == ST_IDLE) && req_valid;
   assign ctrl.scan_step  = (state_ff == ST_SCAN);
   assign ctrl.clear_step = (state_ff == ST_CLEAR);
   assign ctrl.phase      = phase_ff;
   assign ctrl.next_step  = (state_ff == ST_NEXT);
   assign ctrl.exec       = (state_ff == ST_EXEC);
   assign ctrl.last       = last;
   assign ctrl.idx        = idx_ff;
   assign ctrl.op         = op_ff;
   assign ctrl.done       = (state_ff == ST_DONE) && out_free;

endmodule

`default_nettype wire

// ===== rtl/eoq_datapath.sv =====
// Call ranks, counters, destination state and the per-floor rank unit.
`default_nettype none

module eoq_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  eoq_pkg::ctrl_type             ctrl,
   input  logic [eoq_pkg::FLOOR_W-1:0]   req_floor,
   input  logic [eoq_pkg::MASK_W-1:0]    req_up_mask,
   input  logic [eoq_pkg::MASK_W-1:0]    req_down_mask,
   input  logic [eoq_pkg::MASK_W-1:0]    req_cab_mask,
   input  logic                          csr_write_enable,
   input  logic [eoq_pkg::CREDIT_W-1:0]  csr_write_data,
   output logic [eoq_pkg::FLOOR_W-1:0]   dest_floor,
   output logic                          dest_valid,
   output logic [eoq_pkg::DIR_W-1:0]     direction,
   output logic                          stop_here,
   output logic [eoq_pkg::HALL_W-1:0]    hall_count,
   output logic [eoq_pkg::CAB_W-1:0]     cab_count
);
   import eoq_pkg::*;

   logic [HALL_W-1:0]   up_ff [FLOORS];
   logic [HALL_W-1:0]   up_in [FLOORS];
   logic [HALL_W-1:0]   down_ff [FLOORS];
   logic [HALL_W-1:0]   down_in [FLOORS];
   logic [CAB_W-1:0]    cab_ff [FLOORS];
   logic [CAB_W-1:0]    cab_in [FLOORS];
   logic [HALL_W-1:0]   hc_ff, hc_in;
   logic [CAB_W-1:0]    cc_ff, cc_in;
   logic                dv_ff, dv_in;
   logic [FLOOR_W-1:0]  dest_ff, dest_in;
   dir_type             dir_ff, dir_in;
   logic [CREDIT_W-1:0] credit_ff, credit_in;
   logic [CREDIT_W-1:0] limit_ff, limit_in;
   logic                stop_ff, stop_in;
   logic                cab_found_ff, cab_found_in;
   logic [FLOOR_W-1:0]  cab_sel_ff, cab_sel_in;
   logic                hall_found_ff, hall_found_in;
   logic [FLOOR_W-1:0]  hall_sel_ff, hall_sel_in;
   logic [FLOOR_W-1:0]  floor_ff;
   logic [MASK_W-1:0]   um_ff, dm_ff, cm_ff;

   logic [FLOOR_W-1:0]  i;
   logic [HALL_W-1:0]   up_i, down_i, up_fl, down_fl, r_hall, hc_mid;
   logic [CAB_W-1:0]    cab_i, cab_fl;
   logic                skip, up_take, down_take, cab_take;
   logic                hall_act, cab_act, cab_hit, hall_hit;
   logic                cab_found_n, hall_found_n;
   logic [FLOOR_W-1:0]  cab_sel_n, hall_sel_n;
   logic                query;

   assign i       = ctrl.idx;
   assign up_i    = up_ff[i];
   assign down_i  = down_ff[i];
   assign cab_i   = cab_ff[i];
   assign up_fl   = up_ff[floor_ff];
   assign down_fl = down_ff[floor_ff];
   assign cab_fl  = cab_ff[floor_ff];

   // scan
   assign skip      = dv_ff && (i == floor_ff);
   assign up_take   = um_ff[i] && (up_i == '0) && !skip;
   assign down_take = dm_ff[i] && (down_i == '0) && !skip;
   assign cab_take  = cm_ff[i] && (cab_i == '0) && !skip;
   assign hc_mid    = hc_ff + HALL_W'(up_take);

   // clear
   assign r_hall   = (ctrl.phase == PH_UP) ? up_fl : down_fl;
   assign hall_act = (r_hall != '0);
   assign cab_act  = (cab_fl != '0);

   // next destination
   assign cab_hit      = (cab_i == CAB_W'(1));
   assign hall_hit     = (up_i == HALL_W'(1)) || (down_i == HALL_W'(1));
   assign cab_found_n  = cab_found_ff || cab_hit;
   assign cab_sel_n    = cab_found_ff ? cab_sel_ff : i;
   assign hall_found_n = hall_found_ff || hall_hit;
   assign hall_sel_n   = hall_found_ff ? hall_sel_ff : i;

   assign query = (cab_fl != '0) || (dv_ff && (dest_ff == floor_ff)) ||
                  ((up_fl != '0) && (dir_ff == DIR_UP)) ||
                  ((down_fl != '0) && (dir_ff == DIR_DOWN));

   always_comb begin
      up_in         = up_ff;
      down_in       = down_ff;
      cab_in        = cab_ff;
      hc_in         = hc_ff;
      cc_in         = cc_ff;
      dv_in         = dv_ff;
      dest_in       = dest_ff;
      dir_in        = dir_ff;
      credit_in     = credit_ff;
      limit_in      = limit_ff;
      stop_in       = stop_ff;
      cab_found_in  = cab_found_ff;
      cab_sel_in    = cab_sel_ff;
      hall_found_in = hall_found_ff;
      hall_sel_in   = hall_sel_ff;

      if (csr_write_enable) limit_in = csr_write_data;

      if (ctrl.load) begin
         stop_in       = 1'b0;
         cab_found_in  = 1'b0;
         hall_found_in = 1'b0;
      end

      if (ctrl.scan_step) begin
         if (up_take) up_in[i] = hc_ff + 1'b1;
         if (down_take) down_in[i] = hc_mid + 1'b1;
         hc_in = hc_mid + HALL_W'(down_take);
         if (cab_take) cab_in[i] = cc_ff + 1'b1;
         cc_in = cc_ff + CAB_W'(cab_take);
      end

      if (ctrl.clear_step) begin
         if (ctrl.phase == PH_CAB) begin
            if (cab_act && (cab_i > cab_fl)) cab_in[i] = cab_i - 1'b1;
            if (ctrl.last && cab_act) begin
               cab_in[floor_ff] = '0;
               cc_in = cc_ff - 1'b1;
            end
         end else begin
            if (hall_act && (up_i > r_hall)) up_in[i] = up_i - 1'b1;
            if (hall_act && (down_i > r_hall)) down_in[i] = down_i - 1'b1;
            if (ctrl.last && hall_act) begin
               if (ctrl.phase == PH_UP) up_in[floor_ff] = '0;
               else down_in[floor_ff] = '0;
               hc_in = hc_ff - 1'b1;
            end
         end
      end

      if (ctrl.next_step) begin
         cab_found_in  = cab_found_n;
         cab_sel_in    = cab_sel_n;
         hall_found_in = hall_found_n;
         hall_sel_in   = hall_sel_n;
         if (ctrl.last) begin
            if ((credit_ff != '0) && cab_found_n) begin
               dv_in     = 1'b1;
               dest_in   = cab_sel_n;
               credit_in = credit_ff - 1'b1;
            end else if (hall_found_n) begin
               dv_in   = 1'b1;
               dest_in = hall_sel_n;
            end else begin
               dv_in     = 1'b0;
               dest_in   = '0;
               credit_in = limit_ff;
            end
         end
      end

      if (ctrl.exec) begin
         case (ctrl.op)
            OP_DIR: begin
               if (!dv_ff) dir_in = DIR_STOP;
               else if (floor_ff > dest_ff) dir_in = DIR_DOWN;
               else if (floor_ff < dest_ff) dir_in = DIR_UP;
               else dir_in = DIR_STOP;
            end
            OP_STOP: stop_in = query;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff         <= '{default: '0};
         down_ff       <= '{default: '0};
         cab_ff        <= '{default: '0};
         hc_ff         <= '0;
         cc_ff         <= '0;
         dv_ff         <= 1'b0;
         dest_ff       <= '0;
         dir_ff        <= DIR_STOP;
         credit_ff     <= CREDIT_RESET;
         limit_ff      <= CREDIT_RESET;
         stop_ff       <= 1'b0;
         cab_found_ff  <= 1'b0;
         hall_found_ff <= 1'b0;
      end else begin
         up_ff         <= up_in;
         down_ff       <= down_in;
         cab_ff        <= cab_in;
         hc_ff         <= hc_in;
         cc_ff         <= cc_in;
         dv_ff         <= dv_in;
         dest_ff       <= dest_in;
         dir_ff        <= dir_in;
         credit_ff     <= credit_in;
         limit_ff      <= limit_in;
         stop_ff       <= stop_in;
         cab_found_ff  <= cab_found_in;
         hall_found_ff <= hall_found_in;
      end
   end

   always_ff @(posedge clock) begin
      cab_sel_ff  <= cab_sel_in;
      hall_sel_ff <= hall_sel_in;
      if (ctrl.load) begin
         floor_ff <= req_floor;
         um_ff    <= req_up_mask;
         dm_ff    <= req_down_mask;
         cm_ff    <= req_cab_mask;
      end
   end

   assign dest_floor = dest_ff;
   assign dest_valid = dv_ff;
   assign direction  = dir_ff;
   assign stop_here  = stop_ff;
   assign hall_count = hc_ff;
   assign cab_count  = cc_ff;

endmodule

`default_nettype wire

// ===== rtl/elevator_order_queue_core.sv =====
// Elevator order queue top level: sequencer, rank datapath and result register.
// A scan or next destination walks the floors once, a clear makes three rank passes over
// the floors, and the other ops take one execute state; the done state then loads rsp_valid.
// req_ready rises with rsp_valid, so a new request is only taken once the previous result
// is out; an unaccepted result holds the sequencer in its done state.
// Synchronous reset clears ranks and counters, drops the destination, stops, credit 3.
`default_nettype none

module elevator_order_queue_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [eoq_pkg::OP_W-1:0]      req_op,
   input  logic [eoq_pkg::FLOOR_W-1:0]   req_floor,
   input  logic [eoq_pkg::MASK_W-1:0]    req_up_mask,
   input  logic [eoq_pkg::MASK_W-1:0]    req_down_mask,
   input  logic [eoq_pkg::MASK_W-1:0]    req_cab_mask,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [eoq_pkg::FLOOR_W-1:0]   rsp_dest_floor,
   output logic                          rsp_dest_valid,
   output logic [eoq_pkg::DIR_W-1:0]     rsp_direction,
   output logic                          rsp_stop_here,
   output logic [eoq_pkg::HALL_W-1:0]    rsp_hall_count,
   output logic [eoq_pkg::CAB_W-1:0]     rsp_cab_count,
   input  logic                          csr_write_enable,
   input  logic [eoq_pkg::CREDIT_W-1:0]  csr_write_data
);
   import eoq_pkg::*;

   ctrl_type           ctrl;
   logic               out_free;
   logic [FLOOR_W-1:0] dest_floor;
   logic               dest_valid;
   logic [DIR_W-1:0]   direction;
   logic               stop_here;
   logic [HALL_W-1:0]  hall_count;
   logic [CAB_W-1:0]   cab_count;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [FLOOR_W-1:0] rsp_dest_floor_ff;
   logic               rsp_dest_valid_ff;
   logic [DIR_W-1:0]   rsp_direction_ff;
   logic               rsp_stop_here_ff;
   logic [HALL_W-1:0]  rsp_hall_count_ff;
   logic [CAB_W-1:0]   rsp_cab_count_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   eoq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .out_free  (out_free),
      .req_ready (req_ready),
      .ctrl      (ctrl)
   );

   eoq_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .req_floor        (req_floor),
      .req_up_mask      (req_up_mask),
      .req_down_mask    (req_down_mask),
      .req_cab_mask     (req_cab_mask),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .dest_floor       (dest_floor),
      .dest_valid       (dest_valid),
      .direction        (direction),
      .stop_here        (stop_here),
      .hall_count       (hall_count),
      .cab_count        (cab_count)
   );

   assign rsp_valid_in = ctrl.done || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.done) begin
         rsp_dest_floor_ff <= dest_floor;
         rsp_dest_valid_ff <= dest_valid;
         rsp_direction_ff  <= direction;
         rsp_stop_here_ff  <= stop_here;
         rsp_hall_count_ff <= hall_count;
         rsp_cab_count_ff  <= cab_count;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dest_floor = rsp_dest_floor_ff;
   assign rsp_dest_valid = rsp_dest_valid_ff;
   assign rsp_direction  = rsp_direction_ff;
   assign rsp_stop_here  = rsp_stop_here_ff;
   assign rsp_hall_count = rsp_hall_count_ff;
   assign rsp_cab_count  = rsp_cab_count_ff;

endmodule

`default_nettype wire

// ===== rtl/eoq_checker.sv =====
// Port-level checks for the elevator order queue, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module eoq_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [eoq_pkg::FLOOR_W-1:0]  rsp_dest_floor,
   input  logic                         rsp_dest_valid,
   input  logic [eoq_pkg::DIR_W-1:0]    rsp_direction,
   input  logic [eoq_pkg::HALL_W-1:0]   rsp_hall_count,
   input  logic [eoq_pkg::CAB_W-1:0]    rsp_cab_count
);
   import eoq_pkg::*;

   logic no_dest;
   logic counts_ok;

   assign no_dest   = rsp_valid && !rsp_dest_valid;
   assign counts_ok = (rsp_hall_count <= HALL_W'(2 * FLOORS)) &&
                      (rsp_cab_count <= CAB_W'(FLOORS)) &&
                      ((rsp_direction == DIR_STOP) || (rsp_direction == DIR_UP) ||
                       (rsp_direction == DIR_DOWN));

   // busy after a request is taken
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   `ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   `ASSERT_IMPLIES(a_no_dest_floor, clock, reset, no_dest, rsp_dest_floor == '0)

   `ASSERT_IMPLIES(a_counts_bounded, clock, reset, rsp_valid, counts_ok)

endmodule

bind elevator_order_queue_core eoq_checker u_checker (.*);

`default_nettype wire

// ===== sim/elevator_order_queue_core_tb.sv =====
// Self-checking testbench for the elevator order queue core.
`timescale 1ns / 1ps

module elevator_order_queue_core_tb;
   import eoq_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 3 * FLOORS + 4;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [FLOOR_W-1:0] floor_no;
      logic [MASK_W-1:0]  up_mask;
      logic [MASK_W-1:0]  down_mask;
      logic [MASK_W-1:0]  cab_mask;
   } call_req_type;

   typedef struct packed {
      logic [FLOOR_W-1:0] dest_floor;
      logic               dest_valid;
      logic [DIR_W-1:0]   direction;
      logic               stop_here;
      logic [HALL_W-1:0]  hall_count;
      logic [CAB_W-1:0]   cab_count;
   } call_rsp_type;

   class order_scoreboard;
      logic [HALL_W-1:0]   up_rank[FLOORS];
      logic [HALL_W-1:0]   down_rank[FLOORS];
      logic [CAB_W-1:0]    cab_rank[FLOORS];
      logic [HALL_W-1:0]   hall_counter;
      logic [CAB_W-1:0]    cab_counter;
      logic                dest_set;
      logic [FLOOR_W-1:0]  dest;
      dir_type             dir;
      logic [CREDIT_W-1:0] credit;
      logic [CREDIT_W-1:0] credit_limit;
      call_rsp_type        expected_q[$];
      int                  error_count;

      function new();
         for (int i = 0; i < FLOORS; i++) begin
            up_rank[i] = '0;
            down_rank[i] = '0;
            cab_rank[i] = '0;
         end
         hall_counter = '0;
         cab_counter = '0;
         dest_set = 1'b0;
         dest = '0;
         dir = DIR_STOP;
         credit_limit = CREDIT_RESET;
         credit = CREDIT_RESET;
         error_count = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void lower_hall(logic [HALL_W-1:0] r);
         for (int i = 0; i < FLOORS; i++) begin
            if (up_rank[i] > r) up_rank[i]--;
            if (down_rank[i] > r) down_rank[i]--;
         end
      endfunction

      // Apply one accepted request to the queue state and note its response.
      function void note_request(call_req_type r);
         logic [HALL_W-1:0] hr;
         logic [CAB_W-1:0]  cr;
         logic              stop_q;
         logic              found;
         call_rsp_type      e;
         stop_q = 1'b0;
         found = 1'b0;
         case (r.op)
            OP_SCAN: begin
               for (int i = 0; i < FLOORS; i++) begin
                  if (!(i == r.floor_no && dest_set)) begin
                     if (r.up_mask[i] && up_rank[i] == 0) begin
                        hall_counter++;
                        up_rank[i] = hall_counter;
                     end
                     if (r.down_mask[i] && down_rank[i] == 0) begin
                        hall_counter++;
                        down_rank[i] = hall_counter;
                     end
                     if (r.cab_mask[i] && cab_rank[i] == 0) begin
                        cab_counter++;
                        cab_rank[i] = cab_counter;
                     end
                  end
               end
            end
            OP_CLEAR: begin
               hr = up_rank[r.floor_no];
               if (hr != 0) begin
                  lower_hall(hr);
                  hall_counter--;
                  up_rank[r.floor_no] = '0;
               end
               hr = down_rank[r.floor_no];
               if (hr != 0) begin
                  lower_hall(hr);
                  hall_counter--;
                  down_rank[r.floor_no] = '0;
               end
               cr = cab_rank[r.floor_no];
               if (cr != 0) begin
                  for (int i = 0; i < FLOORS; i++)
                     if (cab_rank[i] > cr) cab_rank[i]--;
                  cab_counter--;
                  cab_rank[r.floor_no] = '0;
               end
            end
            OP_NEXT: begin
               if (credit != 0) begin
                  for (int i = 0; i < FLOORS; i++) begin
                     if (!found && cab_rank[i] == 1) begin
                        found = 1'b1;
                        dest_set = 1'b1;
                        dest = FLOOR_W'(i);
                        credit--;
                     end
                  end
               end
               for (int i = 0; i < FLOORS; i++) begin
                  if (!found && (up_rank[i] == 1 || down_rank[i] == 1)) begin
                     found = 1'b1;
                     dest_set = 1'b1;
                     dest = FLOOR_W'(i);
                  end
               end
               if (!found) begin
                  credit = credit_limit;
                  dest_set = 1'b0;
                  dest = '0;
               end
            end
            OP_DIR: begin
               if (!dest_set) dir = DIR_STOP;
               else if (r.floor_no > dest) dir = DIR_DOWN;
               else if (r.floor_no < dest) dir = DIR_UP;
               else dir = DIR_STOP;
            end
            OP_STOP: begin
               stop_q = (cab_rank[r.floor_no] != 0)
                      || (dest_set && dest == r.floor_no)
                      || (up_rank[r.floor_no] != 0 && dir == DIR_UP)
                      || (down_rank[r.floor_no] != 0 && dir == DIR_DOWN);
            end
            default: ;
         endcase
         e.dest_floor = dest_set ? dest : '0;
         e.dest_valid = dest_set;
         e.direction = dir;
         e.stop_here = stop_q;
         e.hall_count = hall_counter;
         e.cab_count = cab_counter;
         expected_q.push_back(e);
      endfunction

      function void compare_field(string name, int exp_v, int act_v);
         if (exp_v != act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            error_count++;
         end
      endfunction

      function void check_result(call_rsp_type a);
         call_rsp_type e;
         if (expected_q.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
            return;
         end
         e = expected_q.pop_front();
         compare_field("dest_floor", e.dest_floor, a.dest_floor);
         compare_field("dest_valid", e.dest_valid, a.dest_valid);
         compare_field("direction", e.direction, a.direction);
         compare_field("stop_here", e.stop_here, a.stop_here);
         compare_field("hall_count", e.hall_count, a.hall_count);
         compare_field("cab_count", e.cab_count, a.cab_count);
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OP_W-1:0]     req_op = '0;
   logic [FLOOR_W-1:0]  req_floor = '0;
   logic [MASK_W-1:0]   req_up_mask = '0;
   logic [MASK_W-1:0]   req_down_mask = '0;
   logic [MASK_W-1:0]   req_cab_mask = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [FLOOR_W-1:0]  rsp_dest_floor;
   logic                rsp_dest_valid;
   logic [DIR_W-1:0]    rsp_direction;
   logic                rsp_stop_here;
   logic [HALL_W-1:0]   rsp_hall_count;
   logic [CAB_W-1:0]    rsp_cab_count;
   logic                csr_write_enable = 1'b0;
   logic [CREDIT_W-1:0] csr_write_data = '0;

   order_scoreboard sb = new();
   int cycle_count = 0;
   int rx_cycle = 0;
   int hold_request = 0;
   int hold_left = 0;
   int burst_left = 0;
   logic [FLOOR_W-1:0] car_floor = '0;
   int stall_pct[4] = '{0, 30, 70, 92};

   elevator_order_queue_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_floor        (req_floor),
      .req_up_mask      (req_up_mask),
      .req_down_mask    (req_down_mask),
      .req_cab_mask     (req_cab_mask),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_dest_floor   (rsp_dest_floor),
      .rsp_dest_valid   (rsp_dest_valid),
      .rsp_direction    (rsp_direction),
      .rsp_stop_here    (rsp_stop_here),
      .rsp_hall_count   (rsp_hall_count),
      .rsp_cab_count    (rsp_cab_count),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** elevator_order_queue_core: FAILED **");
         $finish;
      end
   end

   // Response side: check each accepted response, stall on a rotating pattern.
   always @(posedge clock) begin
      call_rsp_type act;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            act.dest_floor = rsp_dest_floor;
            act.dest_valid = rsp_dest_valid;
            act.direction = rsp_direction;
            act.stop_here = rsp_stop_here;
            act.hall_count = rsp_hall_count;
            act.cab_count = rsp_cab_count;
            sb.check_result(act);
         end
         rx_cycle++;
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct[(rx_cycle / 150) % 4]);
         end
      end
   end

   function automatic logic [MASK_W-1:0] rand_mask();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 15) return '0;
      if (pick < 30) return '1;
      return MASK_W'($urandom_range(0, (1 << MASK_W) - 1));
   endfunction

   task automatic send_request(logic [OP_W-1:0] op, logic [FLOOR_W-1:0] fl,
                               logic [MASK_W-1:0] um, logic [MASK_W-1:0] dm,
                               logic [MASK_W-1:0] cm);
      call_req_type r;
      r.op = op;
      r.floor_no = fl;
      r.up_mask = um;
      r.down_mask = dm;
      r.cab_mask = cm;
      req_valid <= 1'b1;
      req_op <= op;
      req_floor <= fl;
      req_up_mask <= um;
      req_down_mask <= dm;
      req_cab_mask <= cm;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(0, 8);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic send_random_op(logic [OP_W-1:0] op, logic [FLOOR_W-1:0] fl);
      send_request(op, fl, rand_mask(), rand_mask(), rand_mask());
   endtask

   // Wait until every request has been answered and the block has gone quiet.
   task automatic drain();
      if (req_valid) req_valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_credit_limit(logic [CREDIT_W-1:0] v);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      sb.credit_limit = v;
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // One trip: pick a destination, head for it (or to a random floor), ask to stop there, clear it.
   task automatic serve_trip();
      send_random_op(OP_NEXT, car_floor);
      send_random_op(OP_DIR, car_floor);
      if (sb.dest_set && $urandom_range(0, 9) < 7) car_floor = sb.dest;
      else car_floor = FLOOR_W'($urandom_range(0, FLOORS - 1));
      send_random_op(OP_STOP, car_floor);
      send_random_op(OP_CLEAR, car_floor);
   endtask

   task automatic run_random(int n, bit with_hold, bit with_pause);
      int count;
      int pick;
      bit held;
      bit paused;
      logic [OP_W-1:0] op;
      logic [FLOOR_W-1:0] fl;
      count = 0;
      held = 1'b0;
      paused = 1'b0;
      while (count < n) begin
         if (with_hold && !held && count >= 10) begin
            hold_request = HOLD_CYCLES;
            held = 1'b1;
         end
         if (with_pause && !paused && count >= n / 2) begin
            drain();
            paused = 1'b1;
         end
         if ($urandom_range(0, 99) < 35) begin
            serve_trip();
            count += 4;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 30) op = OP_SCAN;
            else if (pick < 46) op = OP_CLEAR;
            else if (pick < 62) op = OP_NEXT;
            else if (pick < 77) op = OP_DIR;
            else if (pick < 95) op = OP_STOP;
            else op = OP_W'($urandom_range(5, 7));
            fl = FLOOR_W'($urandom_range(0, FLOORS - 1));
            if ((op == OP_CLEAR || op == OP_STOP) && sb.dest_set && $urandom_range(0, 1))
               fl = sb.dest;
            send_random_op(op, fl);
            if (op <= OP_STOP) count++;
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // unused codes and empty queue
      send_request(3'd5, 2'd0, '1, '1, '1);
      send_request(3'd6, 2'd1, '0, '1, '0);
      send_request(3'd7, 2'd3, '0, '0, '0);
      send_request(OP_STOP, 2'd0, '0, '0, '0);
      send_request(OP_NEXT, 2'd0, '0, '0, '0);
      send_request(OP_DIR, 2'd2, '0, '0, '0);
      // fill every rank with no destination set: no floor skipped
      send_request(OP_SCAN, 2'd0, '1, '1, '1);
      send_request(OP_STOP, 2'd3, '0, '0, '0);
      send_request(OP_NEXT, 2'd1, '0, '0, '0);
      send_request(OP_DIR, 2'd3, '0, '0, '0);
      send_request(OP_STOP, 2'd2, '0, '0, '0);
      send_request(OP_DIR, 2'd0, '0, '0, '0);
      send_request(OP_CLEAR, 2'd0, '0, '0, '0);
      send_request(OP_CLEAR, 2'd3, '0, '0, '0);
      send_request(OP_CLEAR, 2'd1, '0, '0, '0);
      send_request(OP_CLEAR, 2'd2, '0, '0, '0);
      // destination floor is skipped by the scan
      send_request(OP_SCAN, 2'd0, '1, '1, '1);
      send_request(OP_NEXT, 2'd0, '0, '0, '0);
      send_request(OP_DIR, 2'd0, '0, '0, '0);
      send_request(OP_STOP, 2'd2, '0, '0, '0);
      send_request(OP_DIR, 2'd3, '0, '0, '0);
      send_request(OP_STOP, 2'd2, '0, '0, '0);
      send_request(OP_CLEAR, 2'd1, '0, '0, '0);
      send_request(OP_STOP, 2'd1, '0, '0, '0);

      run_random(100, 1'b0, 1'b0);
      write_credit_limit(4'd0);
      run_random(100, 1'b0, 1'b1);
      write_credit_limit(4'd15);
      run_random(100, 1'b1, 1'b0);
      write_credit_limit(4'd1);
      run_random(100, 1'b0, 1'b0);
      write_credit_limit(CREDIT_W'($urandom_range(2, 14)));
      run_random(100, 1'b0, 1'b0);
      write_credit_limit(4'd2);
      run_random(100, 1'b1, 1'b1);
      drain();

      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("** elevator_order_queue_core: PASSED **");
      end else begin
         $display("** elevator_order_queue_core: FAILED **");
      end
      $finish;
   end

endmodule
